### rtl/ilsu_pkg.sv
package ilsu_pkg;

  localparam int unsigned BlockBytes = 32;
  localparam int unsigned BlockBits  = $clog2(BlockBytes);
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [3:0] {
    OP_LBZ    = 4'd0,
    OP_LHZ    = 4'd1,
    OP_LHA    = 4'd2,
    OP_LHBRX  = 4'd3,
    OP_LWZ    = 4'd4,
    OP_LWBRX  = 4'd5,
    OP_LWARX  = 4'd6,
    OP_STB    = 4'd7,
    OP_STH    = 4'd8,
    OP_STHBRX = 4'd9,
    OP_STW    = 4'd10,
    OP_STWBRX = 4'd11,
    OP_STWCX  = 4'd12,
    OP_DCBZ   = 4'd13,
    OP_ICBI   = 4'd14,
    OP_RETURN = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_ZERO  = 2'd2,
    KIND_INVAL = 2'd3
  } mem_kind_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } mem_size_e;

  typedef enum logic [2:0] {
    FMT_BYTE   = 3'd0,
    FMT_HALF   = 3'd1,
    FMT_HALF_S = 3'd2,
    FMT_HALF_R = 3'd3,
    FMT_WORD   = 3'd4,
    FMT_WORD_R = 3'd5
  } fmt_e;

  typedef struct packed {
    logic [3:0]         operation;
    logic [1:0]         addr_mode;
    logic [4:0]         base_index;
    logic [31:0]        base_value;
    logic [31:0]        index_value;
    logic signed [15:0] displacement;
    logic [4:0]         target_index;
    logic [31:0]        store_value;
    logic               summary_overflow;
    logic [31:0]        read_data;
  } in_item_t;

  typedef struct packed {
    logic        mem_valid;
    logic [1:0]  mem_kind;
    logic [1:0]  mem_size;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
    logic        reg_write_valid;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        cr0_valid;
    logic [3:0]  cr0_value;
  } out_item_t;

  // Classified item passed from the front end to the back end.
  typedef struct packed {
    op_e         op;
    logic        is_return;
    logic        update;
    logic [4:0]  base_index;
    logic [4:0]  target_index;
    logic [31:0] ea;
    logic [31:0] store_value;
    logic        summary_overflow;
    logic [31:0] read_data;
  } work_t;

  function automatic logic [31:0] swap16(logic [31:0] v);
    return {16'h0, v[7:0], v[15:8]};
  endfunction

  function automatic logic [31:0] swap32(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

### rtl/ilsu_front.sv
module ilsu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ilsu_pkg::in_item_t in_item_i,
  output logic               work_valid_o,
  input  logic               work_ready_i,
  output ilsu_pkg::work_t    work_o
);
  import ilsu_pkg::*;

  logic  indexed, update, base_zero;
  logic [31:0] offset;
  work_t work_d, work_q;
  logic  valid_q;
  op_e   op;

  assign op = op_e'(in_item_i.operation);

  always_comb begin
    unique case (op)
      OP_LHBRX, OP_LWBRX, OP_LWARX, OP_STHBRX, OP_STWBRX, OP_STWCX, OP_DCBZ,
      OP_ICBI: begin
        indexed = 1'b1;
        update  = 1'b0;
      end
      default: begin
        indexed = in_item_i.addr_mode[1];
        update  = in_item_i.addr_mode[0];
      end
    endcase
    base_zero = !update && (in_item_i.base_index == 5'd0);
    offset = indexed ? in_item_i.index_value
                     : {{16{in_item_i.displacement[15]}}, in_item_i.displacement};
    work_d.op               = op;
    work_d.is_return        = (op == OP_RETURN);
    work_d.update           = update && (op != OP_RETURN);
    work_d.base_index       = in_item_i.base_index;
    work_d.target_index     = in_item_i.target_index;
    work_d.ea               = (base_zero ? 32'd0 : in_item_i.base_value) + offset;
    work_d.store_value      = in_item_i.store_value;
    work_d.summary_overflow = in_item_i.summary_overflow;
    work_d.read_data        = in_item_i.read_data;
  end

  assign in_ready_o   = !valid_q || work_ready_i;
  assign work_valid_o = valid_q;
  assign work_o       = work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      work_q <= work_d;
    end
  end

endmodule

### rtl/ilsu_queue.sv
module ilsu_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ilsu_pkg::work_t push_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output ilsu_pkg::work_t pop_o
);
  import ilsu_pkg::*;

  localparam int unsigned PtrBits = $clog2(QueueDepth);

  work_t              mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [PtrBits:0]   cnt_q;
  logic               push, pop;

  assign push_ready_o = (cnt_q < (PtrBits+1)'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_o        = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrBits+1)'(QueueDepth)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != '0) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
`endif

endmodule

### rtl/ilsu_back.sv
module ilsu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                work_valid_i,
  output logic                work_ready_o,
  input  ilsu_pkg::work_t     work_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ilsu_pkg::out_item_t out_item_o
);
  import ilsu_pkg::*;

  logic        pend_valid_q, pend_suppress_q, resv_valid_q;
  fmt_e        pend_kind_q;
  logic [4:0]  pend_dest_q;
  logic [31:0] resv_addr_q;
  logic        valid_q, take;
  out_item_t   res_d, res_q;
  logic [31:0] d;
  logic        is_load, sc_ok;
  fmt_e        fmt;

  assign work_ready_o = !valid_q || out_ready_i;
  assign take = work_valid_i && work_ready_o;
  assign out_valid_o = valid_q;
  assign out_item_o  = res_q;
  assign d = work_i.read_data;
  assign is_load = !work_i.is_return && (work_i.op <= OP_LWARX);
  assign sc_ok = resv_valid_q && (resv_addr_q == work_i.ea);

  always_comb begin
    case (work_i.op)
      OP_LBZ:   fmt = FMT_BYTE;
      OP_LHZ:   fmt = FMT_HALF;
      OP_LHA:   fmt = FMT_HALF_S;
      OP_LHBRX: fmt = FMT_HALF_R;
      OP_LWBRX: fmt = FMT_WORD_R;
      default:  fmt = FMT_WORD;
    endcase
  end

  always_comb begin
    res_d = '0;
    if (work_i.is_return) begin
      if (pend_valid_q) begin
        res_d.reg_write_valid = !pend_suppress_q;
        res_d.reg_index       = pend_dest_q;
        case (pend_kind_q)
          FMT_BYTE:   res_d.reg_value = {24'h0, d[7:0]};
          FMT_HALF:   res_d.reg_value = {16'h0, d[15:0]};
          FMT_HALF_S: res_d.reg_value = {{16{d[15]}}, d[15:0]};
          FMT_HALF_R: res_d.reg_value = swap16(d);
          FMT_WORD_R: res_d.reg_value = swap32(d);
          default:    res_d.reg_value = d;
        endcase
      end
    end else begin
      if (work_i.update) begin
        res_d.reg_write_valid = 1'b1;
        res_d.reg_index       = work_i.base_index;
        res_d.reg_value       = work_i.ea;
      end
      unique case (work_i.op)
        OP_LBZ, OP_LHZ, OP_LHA, OP_LHBRX, OP_LWZ, OP_LWBRX, OP_LWARX: begin
          res_d.mem_valid   = 1'b1;
          res_d.mem_kind    = KIND_READ;
          res_d.mem_address = work_i.ea;
          res_d.mem_size    = (work_i.op == OP_LBZ) ? SIZE_BYTE :
                              (work_i.op <= OP_LHBRX) ? SIZE_HALF : SIZE_WORD;
        end
        OP_STB, OP_STH, OP_STHBRX, OP_STW, OP_STWBRX: begin
          res_d.mem_valid   = 1'b1;
          res_d.mem_kind    = KIND_WRITE;
          res_d.mem_address = work_i.ea;
          unique case (work_i.op)
            OP_STB: begin
              res_d.mem_size = SIZE_BYTE;
              res_d.mem_write_data = {24'h0, work_i.store_value[7:0]};
            end
            OP_STH: begin
              res_d.mem_size = SIZE_HALF;
              res_d.mem_write_data = {16'h0, work_i.store_value[15:0]};
            end
            OP_STHBRX: begin
              res_d.mem_size = SIZE_HALF;
              res_d.mem_write_data = swap16(work_i.store_value);
            end
            OP_STW: begin
              res_d.mem_size = SIZE_WORD;
              res_d.mem_write_data = work_i.store_value;
            end
            default: begin
              res_d.mem_size = SIZE_WORD;
              res_d.mem_write_data = swap32(work_i.store_value);
            end
          endcase
        end
        OP_STWCX: begin
          res_d.cr0_valid = 1'b1;
          res_d.cr0_value = {2'b00, sc_ok, work_i.summary_overflow};
          if (sc_ok) begin
            res_d.mem_valid      = 1'b1;
            res_d.mem_kind       = KIND_WRITE;
            res_d.mem_size       = SIZE_WORD;
            res_d.mem_address    = work_i.ea;
            res_d.mem_write_data = work_i.store_value;
          end
        end
        default: begin
          res_d.mem_valid   = 1'b1;
          res_d.mem_kind    = (work_i.op == OP_DCBZ) ? KIND_ZERO : KIND_INVAL;
          res_d.mem_address = {work_i.ea[31:BlockBits], BlockBits'(0)};
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q         <= 1'b0;
      pend_valid_q    <= 1'b0;
      pend_kind_q     <= FMT_BYTE;
      pend_dest_q     <= '0;
      pend_suppress_q <= 1'b0;
      resv_valid_q    <= 1'b0;
      resv_addr_q     <= '0;
    end else begin
      if (work_ready_o) valid_q <= work_valid_i;
      if (take) begin
        if (work_i.is_return) begin
          pend_valid_q <= 1'b0;
        end else if (is_load) begin
          pend_valid_q    <= 1'b1;
          pend_kind_q     <= fmt;
          pend_dest_q     <= work_i.target_index;
          pend_suppress_q <= work_i.update && (work_i.base_index == work_i.target_index);
          if (work_i.op == OP_LWARX) begin
            resv_valid_q <= 1'b1;
            resv_addr_q  <= work_i.ea;
          end
        end else if (work_i.op == OP_STWCX) begin
          resv_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(res_q))
    else $error("result dropped while stalled");
  a_sc_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !work_i.is_return && work_i.op == OP_STWCX) |=> !resv_valid_q)
    else $error("reservation survived store-conditional");
  a_return_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && work_i.is_return) |=> !pend_valid_q)
    else $error("pending load survived its return");
`endif

endmodule

### rtl/integer_load_store_unit.sv
// Path: an accepted beat's result passes through the front register, the queue and
// the result register before it is presented, and is held there while the output
// is stalled.
// Throughput: one beat per cycle while the output is not stalled; the two-entry queue
// lets the address front end keep accepting during a result-side stall until it fills.
// Reset: asynchronous active low; clears the pending load and the reservation.
module integer_load_store_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ilsu_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ilsu_pkg::out_item_t out_item_o
);
  import ilsu_pkg::*;

  logic  f_valid, f_ready, q_valid, q_ready;
  work_t f_work, q_work;

  ilsu_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .work_valid_o(f_valid), .work_ready_i(f_ready), .work_o(f_work)
  );

  ilsu_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_i(f_work),
    .pop_valid_o(q_valid), .pop_ready_i(q_ready), .pop_o(q_work)
  );

  ilsu_back u_back (
    .clk_i, .rst_ni,
    .work_valid_i(q_valid), .work_ready_o(q_ready), .work_i(q_work),
    .out_valid_o, .out_ready_i, .out_item_o
  );

endmodule
